// ===== rtl/rsss_pkg.sv =====
// Package for the ring scan stop scheduler.
// Types, codes and sizes shared by the top level and the distance unit.
package rsss_pkg;

    localparam int MaxStations = 16;
    localparam int StIdxW      = 4;   // bits to index a station
    localparam int PosW        = 8;   // ring positions, max 16*15 = 240

    // func codes of an input item
    localparam logic [1:0] FuncTick = 2'd0;
    localparam logic [1:0] FuncStop = 2'd1;
    localparam logic [1:0] FuncCw   = 2'd2;
    localparam logic [1:0] FuncCcw  = 2'd3;

    // heading codes
    localparam logic [1:0] HeadIdle = 2'b00;
    localparam logic [1:0] HeadCw   = 2'b01;
    localparam logic [1:0] HeadCcw  = 2'b11;

    // register indexes
    localparam logic RegSpacing = 1'b0;
    localparam logic RegCount   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_SCAN,
        ST_APPLY,
        ST_FIN
    } state_t;

    // distance of one station from the vehicle
    typedef struct packed {
        logic [PosW-1:0] cw;
        logic [PosW-1:0] ccw;
        logic            cw_le_ccw;
        logic            cw_near;    // cw  within half the ring
        logic            ccw_near;   // ccw within half the ring
    } dist_t;

endpackage

// ===== rtl/ring_scan_stop_scheduler.sv =====
// Top level of the ring scan stop scheduler: APB registers, station
// bitmaps, tick sequencer. Uses rsss_pkg and rsss_dist.
//
//  channel | ports            | fields (low bit up)
//  --------+------------------+---------------------------------------------
//  input   | s_tvalid/tready  | func[1:0], station[6:2], pad
//  result  | m_tvalid/tready  | position[7:0], heading[9:8], stopped[10],
//          |                  | elapsed[42:11], pad
//  config  | APB              | 0x0 station_spacing, 0x4 station_count
//
// A request item passes through the accept state and the result load.
// A tick passes through the accept state, eight steps of a restoring
// remainder that fold the position onto the ring, one step per station in
// the distance unit, the apply state and the result load.
// Reset (aresetn low, synchronous) clears all flags, the position and the tick counter.
// s_tready is high only in idle; a result waiting in the output register does
// not block the next input, only the next result load.
module ring_scan_stop_scheduler import rsss_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // func[1:0], station[6:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // position, heading, stopped, elapsed
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    // configuration
    logic [3:0] spacing_reg;
    logic [4:0] count_reg;

    // scheduler state
    logic [PosW-1:0]  pos_reg, pos_next;
    logic [1:0]       head_reg, head_next;
    logic             first_reg, first_next;
    logic [31:0]      ticks_reg, ticks_next;
    logic [2:0]       flags_reg [MaxStations], flags_next [MaxStations];
    logic [2:0]       armed_reg [MaxStations], armed_next [MaxStations];
    logic [2:0]       fresh_reg [MaxStations], fresh_next [MaxStations];

    // sequencer
    state_t           state_reg, state_next;
    logic [2:0]       bit_reg, bit_next;
    logic [StIdxW-1:0] k_reg, k_next;
    logic [PosW-1:0]  rem_reg, rem_next;
    logic [PosW-1:0]  len_reg, len_next;
    logic [3:0]       sp_reg, sp_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic [PosW-1:0]  acc_reg, acc_next;
    logic [PosW:0]    bcw_reg, bcw_next, bccw_reg, bccw_next;
    logic             any_reg, any_next, keep_reg, keep_next;
    logic             hit_reg, hit_next, served_reg, served_next;
    logic [StIdxW-1:0] hidx_reg, hidx_next;

    // output register
    logic             mv_reg, mv_next;
    logic [47:0]      md_reg, md_next;

    logic [3:0]       eff_sp;
    logic [4:0]       eff_cnt;
    logic [1:0]       in_func;
    logic [4:0]       in_st;
    logic [StIdxW-1:0] req_idx;
    logic [2:0]       req_bit;
    logic [PosW:0]    rem_sh;
    dist_t            dinfo;

    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign prdata   = paddr[2] ? {27'd0, count_reg} : {28'd0, spacing_reg};

    assign eff_sp  = (spacing_reg == 4'd0) ? 4'd1 : spacing_reg;
    assign eff_cnt = (count_reg < 5'd2) ? 5'd2 :
                     (count_reg > 5'(MaxStations)) ? 5'(MaxStations) : count_reg;
    assign in_func = s_tdata[1:0];
    assign in_st   = s_tdata[6:2];
    assign req_idx = StIdxW'(in_st - 5'd1);
    assign rem_sh  = {rem_reg, pos_reg[bit_reg]};

    rsss_dist u_dist (
        .stn_pos  (acc_reg),
        .veh_pos  (pos_reg),
        .ring_len (len_reg),
        .dinfo    (dinfo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spacing_reg <= 4'd2;
            count_reg   <= 5'd10;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == RegCount) begin
                count_reg <= pwdata[4:0];
            end else begin
                spacing_reg <= pwdata[3:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            head_reg  <= HeadIdle;
            first_reg <= 1'b1;
            ticks_reg <= '0;
            mv_reg    <= 1'b0;
            for (int i = 0; i < MaxStations; i++) begin
                flags_reg[i] <= '0;
                armed_reg[i] <= '0;
                fresh_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            head_reg  <= head_next;
            first_reg <= first_next;
            ticks_reg <= ticks_next;
            mv_reg    <= mv_next;
            flags_reg <= flags_next;
            armed_reg <= armed_next;
            fresh_reg <= fresh_next;
        end
        bit_reg    <= bit_next;
        k_reg      <= k_next;
        rem_reg    <= rem_next;
        len_reg    <= len_next;
        sp_reg     <= sp_next;
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        bcw_reg    <= bcw_next;
        bccw_reg   <= bccw_next;
        any_reg    <= any_next;
        keep_reg   <= keep_next;
        hit_reg    <= hit_next;
        hidx_reg   <= hidx_next;
        served_reg <= served_next;
        md_reg     <= md_next;
    end

    always_comb begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        head_next   = head_reg;
        first_next  = first_reg;
        ticks_next  = ticks_reg;
        flags_next  = flags_reg;
        armed_next  = armed_reg;
        fresh_next  = fresh_reg;
        bit_next    = bit_reg;
        k_next      = k_reg;
        rem_next    = rem_reg;
        len_next    = len_reg;
        sp_next     = sp_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        bcw_next    = bcw_reg;
        bccw_next   = bccw_reg;
        any_next    = any_reg;
        keep_next   = keep_reg;
        hit_next    = hit_reg;
        hidx_next   = hidx_reg;
        served_next = served_reg;
        mv_next     = mv_reg && !m_tready;
        md_next     = md_reg;
        req_bit     = 3'b001 << (in_func - 2'd1);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    served_next = 1'b0;
                    if (in_func == FuncTick) begin
                        ticks_next = ticks_reg + 32'd1;
                        sp_next    = eff_sp;
                        cnt_next   = eff_cnt;
                        len_next   = {3'd0, eff_cnt} * {4'd0, eff_sp};
                        rem_next   = '0;
                        bit_next   = 3'd7;
                        state_next = ST_MOD;
                    end else begin
                        if (in_st >= 5'd1 && in_st <= eff_cnt &&
                            (flags_reg[req_idx] & req_bit) == 3'b000) begin
                            flags_next[req_idx] = flags_reg[req_idx] | req_bit;
                            fresh_next[req_idx] = fresh_reg[req_idx] | req_bit;
                        end
                        state_next = ST_FIN;
                    end
                end
            end
            ST_MOD: begin
                // one remainder bit per cycle: pos mod len
                if (rem_sh >= {1'b0, len_reg}) begin
                    rem_next = PosW'(rem_sh - {1'b0, len_reg});
                end else begin
                    rem_next = rem_sh[PosW-1:0];
                end
                bit_next = bit_reg - 3'd1;
                if (bit_reg == 3'd0) begin
                    pos_next   = rem_next;
                    k_next     = '0;
                    acc_next   = '0;
                    bcw_next   = {1'b0, len_reg} + 9'd1;
                    bccw_next  = {1'b0, len_reg} + 9'd1;
                    any_next   = 1'b0;
                    keep_next  = 1'b0;
                    hit_next   = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (acc_reg == pos_reg && armed_reg[k_reg] != 3'b000) begin
                    hit_next  = 1'b1;
                    hidx_next = k_reg;
                end
                if ((armed_reg[k_reg] | fresh_reg[k_reg]) != 3'b000) begin
                    any_next = 1'b1;
                    if (dinfo.cw_le_ccw) begin
                        if ({1'b0, dinfo.cw} < bcw_reg) bcw_next = {1'b0, dinfo.cw};
                    end else begin
                        if ({1'b0, dinfo.ccw} < bccw_reg) bccw_next = {1'b0, dinfo.ccw};
                    end
                    if ((head_reg == HeadCw && dinfo.cw_near) ||
                        (head_reg == HeadCcw && dinfo.ccw_near)) begin
                        keep_next = 1'b1;
                    end
                end
                acc_next = acc_reg + PosW'(sp_reg);
                k_next   = k_reg + 1'b1;
                if ({1'b0, k_reg} == cnt_reg - 5'd1) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                head_next = head_reg;
                if (hit_reg) begin
                    armed_next[hidx_reg] = '0;
                    flags_next[hidx_reg] = '0;
                    served_next = 1'b1;
                end else begin
                    if (!any_reg) begin
                        head_next  = HeadIdle;
                        first_next = 1'b1;
                    end else if (first_reg) begin
                        first_next = 1'b0;
                        head_next  = (bcw_reg <= bccw_reg) ? HeadCw : HeadCcw;
                    end else if (!keep_reg) begin
                        head_next  = (head_reg == HeadCw) ? HeadCcw :
                                     (head_reg == HeadCcw) ? HeadCw : HeadIdle;
                    end
                    if (head_next == HeadCw) begin
                        pos_next = (pos_reg + 8'd1 >= len_reg) ? '0 : pos_reg + 8'd1;
                    end else if (head_next == HeadCcw) begin
                        pos_next = (pos_reg == '0) ? len_reg - 8'd1 : pos_reg - 8'd1;
                    end
                end
                // fresh requests become armed after the tick
                for (int i = 0; i < MaxStations; i++) begin
                    armed_next[i] = armed_next[i] | fresh_reg[i];
                    fresh_next[i] = '0;
                end
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    md_next    = {5'd0, ticks_reg, served_reg, head_reg, pos_reg};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// ===== rtl/rsss_dist.sv =====
// Distance unit: clockwise and counterclockwise distance of one station.
// Shared over all stations by the scan sequencer. Uses rsss_pkg.
module rsss_dist import rsss_pkg::*; (
    input  logic [PosW-1:0] stn_pos,
    input  logic [PosW-1:0] veh_pos,
    input  logic [PosW-1:0] ring_len,
    output dist_t           dinfo
);
    logic [PosW-1:0] cw;
    logic [PosW-1:0] ccw;
    logic [PosW-1:0] half;

    always_comb begin
        if (stn_pos >= veh_pos) begin
            cw = stn_pos - veh_pos;
        end else begin
            cw = stn_pos + ring_len - veh_pos;
        end
        ccw  = ring_len - cw;
        half = ring_len >> 1;
        dinfo.cw        = cw;
        dinfo.ccw       = ccw;
        dinfo.cw_le_ccw = (cw <= ccw);
        dinfo.cw_near   = (cw <= half);
        dinfo.ccw_near  = (ccw <= half);
    end
endmodule
